>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl/core modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/tprp_pkg.sv
// types and codes for the turtle pen raster plotter
// no dependencies
`default_nettype none

package tprp_pkg;

    typedef enum logic [2:0] {
        CMD_PEN_UP,
        CMD_PEN_DOWN,
        CMD_ERASE,
        CMD_TURN_R,
        CMD_TURN_L,
        CMD_MOVE,
        CMD_READ_ROW,
        CMD_CLEAR
    } cmd_t;

    typedef enum logic [1:0] {
        HD_RIGHT,
        HD_DOWN,
        HD_LEFT,
        HD_UP
    } heading_t;

    typedef enum logic [1:0] {
        MODE_UP,
        MODE_DOWN,
        MODE_ERASE
    } mode_t;

    localparam int POS_W  = 5;
    localparam int STEP_W = 8;
    localparam int RSEL_W = 5;
    localparam int ROWB_W = 32;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ROWB_W-1:0] row_bits_t;

endpackage

`default_nettype wire

>>> rtl/core/turtle_pen_raster_plotter_unit.sv
// turtle pen raster plotter: pen state machine over a bit grid held in one memory
// depends on tprp_pkg and assert_macros.svh
//
// usage
//   command channel: cmd, steps, row_select are taken at a rising edge where
//   start is high and busy is low. busy stays high until the command's result.
//   result channel: done is high for exactly one cycle; pos_x, pos_y, heading,
//   pen_mode and row_bits hold that transaction's result in that cycle. the
//   receiver cannot stall, so the block never waits on it.
//   states passed from accept to the cycle with done high:
//     pen mode, turn, clear, move with pen up: plan
//     read row, move along a row with pen down or erasing: plan, then row read or row write
//     move along a column with pen down or erasing: plan, then column write for each row
//   a new command may be accepted in the cycle where done is high, so a
//   command is taken only once the last one is through; the grid memory has
//   one read port and one write port and is updated one row per cycle.
//   the grid is one row per memory word with a per-row valid flag; reset and
//   the clear command drop all flags at once, so there is no clearing pass.
//   reset puts the pen at column 0, row 0, heading right, pen up.
`default_nettype none

`include "assert_macros.svh"

module turtle_pen_raster_plotter_unit
    import tprp_pkg::*;
#(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        cmd,
    input  wire logic [STEP_W-1:0] steps,
    input  wire logic [RSEL_W-1:0] row_select,
    output logic                   done,
    output logic [POS_W-1:0]       pos_x,
    output logic [POS_W-1:0]       pos_y,
    output logic [1:0]             heading,
    output logic [1:0]             pen_mode,
    output logic [ROWB_W-1:0]      row_bits
);

    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);
    localparam int SW = STEP_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_ROWRD,
        ST_HROW,
        ST_VROW
    } state_t;

    typedef logic [GRID_COLS-1:0] row_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [STEP_W-1:0]   steps_reg;
    logic [RSEL_W-1:0]   rsel_reg;
    logic [XW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    heading_t            hd_reg;
    mode_t               mode_reg;
    logic [YW-1:0]       row_reg;
    logic [YW-1:0]       hi_reg;
    row_t                mask_reg;
    row_bits_t           row_bits_reg;
    logic                done_reg;
    logic [GRID_ROWS-1:0] valid_reg;

    // grid memory, synchronous read
    row_t                mem [GRID_ROWS];
    row_t                rdata_reg;
    logic                rvalid_reg;

    logic                accept;
    logic                horiz;
    logic [XW-1:0]       end_x;
    logic [YW-1:0]       end_y;
    logic [XW-1:0]       lo_x;
    logic [XW-1:0]       hi_x;
    logic [YW-1:0]       lo_y;
    logic [YW-1:0]       hi_y;
    logic [SW-1:0]       sum_x;
    logic [SW-1:0]       sum_y;
    row_t                hmask;
    row_t                vmask;
    row_t                rd_row;
    logic                rsel_ok;
    logic                rd_en;
    logic [YW-1:0]       rd_addr;
    logic                wr_en;
    logic [YW-1:0]       wr_addr;
    row_t                wr_data;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign pos_x   = pos_t'(x_reg);
    assign pos_y   = pos_t'(y_reg);
    assign heading = hd_reg;
    assign pen_mode = mode_reg;
    assign row_bits = row_bits_reg;

    assign rd_row  = rvalid_reg ? rdata_reg : '0;
    assign rsel_ok = (int'(rsel_reg) < GRID_ROWS);
    assign horiz   = (hd_reg == HD_RIGHT) || (hd_reg == HD_LEFT);

    // end point of a move, clamped at the grid edge
    always_comb
    begin
        sum_x = SW'(x_reg) + SW'(steps_reg);
        sum_y = SW'(y_reg) + SW'(steps_reg);
        end_x = x_reg;
        end_y = y_reg;
        unique case (hd_reg)
            HD_RIGHT:
            begin
                end_x = (sum_x > SW'(GRID_COLS - 1)) ? XW'(GRID_COLS - 1) : XW'(sum_x);
            end
            HD_DOWN:
            begin
                end_y = (sum_y > SW'(GRID_ROWS - 1)) ? YW'(GRID_ROWS - 1) : YW'(sum_y);
            end
            HD_LEFT:
            begin
                end_x = (SW'(x_reg) > SW'(steps_reg)) ? XW'(SW'(x_reg) - SW'(steps_reg))
                                                      : '0;
            end
            HD_UP:
            begin
                end_y = (SW'(y_reg) > SW'(steps_reg)) ? YW'(SW'(y_reg) - SW'(steps_reg))
                                                      : '0;
            end
            default:
            begin
                end_x = x_reg;
                end_y = y_reg;
            end
        endcase
        lo_x = (end_x < x_reg) ? end_x : x_reg;
        hi_x = (end_x < x_reg) ? x_reg : end_x;
        lo_y = (end_y < y_reg) ? end_y : y_reg;
        hi_y = (end_y < y_reg) ? y_reg : end_y;
        for (int i = 0; i < GRID_COLS; i++)
        begin
            hmask[i] = (i >= int'(lo_x)) && (i <= int'(hi_x));
            vmask[i] = (i == int'(x_reg));
        end
    end

    // memory port control; one row per cycle, reads and writes always hit different rows
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = (mode_reg == MODE_ERASE) ? (rd_row & ~mask_reg) : (rd_row | mask_reg);
        unique case (state_reg)
            ST_PLAN:
            begin
                if (cmd_reg == CMD_READ_ROW)
                begin
                    rd_en   = rsel_ok;
                    rd_addr = YW'(rsel_reg);
                end
                else if ((cmd_reg == CMD_MOVE) && (mode_reg != MODE_UP))
                begin
                    rd_en   = 1'b1;
                    rd_addr = horiz ? y_reg : lo_y;
                end
            end
            ST_HROW:
            begin
                wr_en   = 1'b1;
                wr_addr = y_reg;
            end
            ST_VROW:
            begin
                wr_en   = 1'b1;
                wr_addr = row_reg;
                rd_en   = (row_reg != hi_reg);
                rd_addr = YW'(row_reg + 1'b1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= CMD_PEN_UP;
            steps_reg    <= '0;
            rsel_reg     <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            hd_reg       <= HD_RIGHT;
            mode_reg     <= MODE_UP;
            row_reg      <= '0;
            hi_reg       <= '0;
            mask_reg     <= '0;
            row_bits_reg <= '0;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rvalid_reg <= rd_en ? valid_reg[rd_addr] : 1'b0;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg      <= cmd_t'(cmd);
                        steps_reg    <= steps;
                        rsel_reg     <= row_select;
                        row_bits_reg <= '0;
                        state_reg    <= ST_PLAN;
                    end
                end
                ST_PLAN:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                    unique case (cmd_reg)
                        CMD_PEN_UP:   mode_reg <= MODE_UP;
                        CMD_PEN_DOWN: mode_reg <= MODE_DOWN;
                        CMD_ERASE:    mode_reg <= MODE_ERASE;
                        CMD_TURN_R:   hd_reg   <= heading_t'(hd_reg + 2'd1);
                        CMD_TURN_L:   hd_reg   <= heading_t'(hd_reg + 2'd3);
                        CMD_MOVE:
                        begin
                            x_reg    <= end_x;
                            y_reg    <= end_y;
                            row_reg  <= lo_y;
                            hi_reg   <= hi_y;
                            mask_reg <= horiz ? hmask : vmask;
                            if (mode_reg != MODE_UP)
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= horiz ? ST_HROW : ST_VROW;
                            end
                        end
                        CMD_READ_ROW:
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= ST_ROWRD;
                        end
                        CMD_CLEAR:
                        begin
                            x_reg     <= '0;
                            y_reg     <= '0;
                            hd_reg    <= HD_RIGHT;
                            mode_reg  <= MODE_UP;
                            valid_reg <= '0;
                        end
                        default:
                        begin
                            mode_reg <= mode_reg;
                        end
                    endcase
                end
                ST_ROWRD:
                begin
                    row_bits_reg <= row_bits_t'(rd_row);
                    done_reg     <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                ST_HROW:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_VROW:
                begin
                    row_reg <= YW'(row_reg + 1'b1);
                    if (row_reg == hi_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_done_idle, done_reg, state_reg == ST_IDLE)
    `ASSERT_IMPLY(a_no_same_row, wr_en && rd_en, wr_addr != rd_addr)
    `ASSERT_NEXT(a_accept_plan, accept, state_reg == ST_PLAN)
    `ASSERT_IMPLY(a_vrow_range, state_reg == ST_VROW, row_reg <= hi_reg)

endmodule

`default_nettype wire
